[sv/ppp_pkg.sv]
// Shared types, widths and helpers for the pinhole point projection block.
`default_nettype none
package ppp_pkg;

  // Field and register widths.
  localparam int COORD_W = 32;
  localparam int ENTRY_W = 21;
  localparam int REG_W   = 3 * ENTRY_W;
  localparam int IDX_W   = 3;

  // Datapath widths: difference, rotation products, rotated point,
  // intrinsic products and homogeneous result.
  localparam int DIFF_W  = COORD_W + 1;
  localparam int P1_W    = ENTRY_W + DIFF_W;
  localparam int SUM1_W  = P1_W + 2;
  localparam int ROT_SH  = 18;
  localparam int ROT_W   = SUM1_W - ROT_SH;
  localparam int P2_W    = ENTRY_W + ROT_W;
  localparam int H_W     = P2_W + 2;

  // Divider geometry: 33 quotient bits of (a * 2^16) / b.
  localparam int FRAC_W    = 16;
  localparam int QUO_W     = COORD_W + 1;
  localparam int LO_W      = QUO_W - FRAC_W;
  localparam int DIV_STEPS = QUO_W;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_K_A   = 3'd0;
  localparam logic [IDX_W-1:0] REG_K_B   = 3'd1;
  localparam logic [IDX_W-1:0] REG_K_C   = 3'd2;
  localparam logic [IDX_W-1:0] REG_R_A   = 3'd3;
  localparam logic [IDX_W-1:0] REG_R_B   = 3'd4;
  localparam logic [IDX_W-1:0] REG_R_C   = 3'd5;
  localparam logic [IDX_W-1:0] REG_CAM   = 3'd6;

  // Configuration as seen by the front.
  typedef struct packed {
    logic [REG_W-1:0] k_a;
    logic [REG_W-1:0] k_b;
    logic [REG_W-1:0] k_c;
    logic [REG_W-1:0] r_a;
    logic [REG_W-1:0] r_b;
    logic [REG_W-1:0] r_c;
    logic [REG_W-1:0] cam;
  } cfg_t;

  // One queued word: the homogeneous pixel vector.
  typedef struct packed {
    logic [H_W-1:0] h0;
    logic [H_W-1:0] h1;
    logic [H_W-1:0] h2;
  } hvec_t;

  // Picks signed entry j out of a packed register.
  function automatic logic signed [ENTRY_W-1:0] entry_of(input logic [REG_W-1:0] r,
                                                          input int j);
    return $signed(r[ENTRY_W*j +: ENTRY_W]);
  endfunction

endpackage
`default_nettype wire

[sv/ppp_queue.sv]
// Small first-in first-out queue between the front and the back.
`default_nettype none
module ppp_queue #(
  parameter int DEPTH = ppp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  ppp_pkg::hvec_t     push_data,
  input  wire logic          pop,
  output ppp_pkg::hvec_t     head,
  output logic               full,
  output logic               empty
);
  import ppp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hvec_t            store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = store[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

[sv/ppp_front.sv]
// Front: camera-frame transform and intrinsic product, five pipeline stages.
`default_nettype none
module ppp_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  ppp_pkg::cfg_t                       cfg,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] point_x,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] point_y,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] point_z,
  input  wire logic                           q_full,
  output logic                                q_push,
  output ppp_pkg::hvec_t                      q_data
);
  import ppp_pkg::*;

  logic signed [ENTRY_W-1:0] cam_e [3];
  logic signed [ENTRY_W-1:0] rot_e [3][3];
  logic signed [ENTRY_W-1:0] k_e   [3][3];
  logic signed [COORD_W-1:0] pt    [3];
  logic signed [SUM1_W-1:0]  sum1  [3];

  logic signed [DIFF_W-1:0]  d  [3];
  logic signed [P1_W-1:0]    p1 [3][3];
  logic signed [ROT_W-1:0]   qv [3];
  logic signed [P2_W-1:0]    p2 [3][3];
  logic signed [H_W-1:0]     h  [3];
  logic [4:0]                v;
  logic                      en;

  // The whole front moves unless its last word cannot enter the queue.
  assign en       = !(v[4] && q_full);
  assign in_stall = !en;
  assign q_push   = v[4] && !q_full;
  assign q_data   = '{h0: h[0], h1: h[1], h2: h[2]};

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  // Unpack configuration entries and form the rotated sums.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cam_e[j]    = entry_of(cfg.cam, j);
      rot_e[0][j] = entry_of(cfg.r_a, j);
      rot_e[1][j] = entry_of(cfg.r_b, j);
      rot_e[2][j] = entry_of(cfg.r_c, j);
      k_e[0][j]   = entry_of(cfg.k_a, j);
      k_e[1][j]   = entry_of(cfg.k_b, j);
      k_e[2][j]   = entry_of(cfg.k_c, j);
    end
    for (int i = 0; i < 3; i++) begin
      sum1[i] = SUM1_W'(p1[i][0]) + SUM1_W'(p1[i][1]) + SUM1_W'(p1[i][2]);
    end
  end

  // Valid tracking through the five stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        d[j] <= {pt[j][COORD_W-1], pt[j]} -
                {{(DIFF_W-ENTRY_W-6){cam_e[j][ENTRY_W-1]}}, cam_e[j], 6'b0};
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p1[i][j] <= rot_e[j][i] * d[j];
        end
      end
      // Floor of the sum over 2^18 is its upper bits.
      for (int i = 0; i < 3; i++) begin
        qv[i] <= sum1[i][SUM1_W-1:ROT_SH];
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p2[i][j] <= k_e[i][j] * qv[j];
        end
      end
      for (int i = 0; i < 3; i++) begin
        h[i] <= H_W'(p2[i][0]) + H_W'(p2[i][1]) + H_W'(p2[i][2]);
      end
    end
  end

endmodule
`default_nettype wire

[sv/ppp_back.sv]
// Back: pipelined restoring divide by depth, saturation and output register.
`default_nettype none
module ppp_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  ppp_pkg::hvec_t                      head,
  input  wire logic                           q_empty,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [ppp_pkg::COORD_W-1:0]  pixel_u,
  output logic signed [ppp_pkg::COORD_W-1:0]  pixel_v,
  output logic                                in_front,
  output logic                                depth_zero
);
  import ppp_pkg::*;

  // State carried by one division stage.
  typedef struct packed {
    logic [H_W-1:0]   r_u;
    logic [H_W-1:0]   r_v;
    logic [H_W-1:0]   b;
    logic [LO_W-1:0]  lo_u;
    logic [LO_W-1:0]  lo_v;
    logic [QUO_W-1:0] q_u;
    logic [QUO_W-1:0] q_v;
    logic             neg_u;
    logic             neg_v;
    logic             ovf_u;
    logic             ovf_v;
    logic             front;
    logic             zero;
  } div_t;

  localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(33'h080000000);
  localparam logic [COORD_W-1:0] MIN_W = 32'h80000000;
  localparam logic [COORD_W-1:0] MAX_W = 32'h7FFFFFFF;

  div_t             st [DIV_STEPS+1];
  logic             vs [DIV_STEPS+1];
  logic             en;
  logic signed [H_W-1:0] h0, h1, h2;
  logic [H_W-1:0]   a0, a1, bb;
  div_t             st0_next;
  div_t             last;

  // One restoring step: returns the quotient bit over the new remainder.
  function automatic logic [H_W:0] div_bit(input logic [H_W-1:0] r, input logic n,
                                           input logic [H_W-1:0] b);
    logic [H_W:0] t;
    logic [H_W:0] diff;
    t    = {r, n};
    diff = t - {1'b0, b};
    if (t >= {1'b0, b}) begin
      return {1'b1, diff[H_W-1:0]};
    end
    return {1'b0, t[H_W-1:0]};
  endfunction

  // The back advances as one unit whenever the output word can move.
  assign en        = !out_valid || !out_stall;
  assign q_pop     = en && !q_empty;
  assign last      = st[DIV_STEPS];

  // Sign split, overflow test and depth flags on the queue head.
  always_comb begin
    h0 = $signed(head.h0);
    h1 = $signed(head.h1);
    h2 = $signed(head.h2);
    a0 = h0[H_W-1] ? H_W'(-h0) : H_W'(h0);
    a1 = h1[H_W-1] ? H_W'(-h1) : H_W'(h1);
    bb = h2[H_W-1] ? H_W'(-h2) : H_W'(h2);
    st0_next.r_u   = a0 >> LO_W;
    st0_next.r_v   = a1 >> LO_W;
    st0_next.b     = bb;
    st0_next.lo_u  = a0[LO_W-1:0];
    st0_next.lo_v  = a1[LO_W-1:0];
    st0_next.q_u   = '0;
    st0_next.q_v   = '0;
    st0_next.neg_u = h0[H_W-1] ^ h2[H_W-1];
    st0_next.neg_v = h1[H_W-1] ^ h2[H_W-1];
    st0_next.ovf_u = (a0 >> LO_W) >= bb;
    st0_next.ovf_v = (a1 >> LO_W) >= bb;
    st0_next.front = !h2[H_W-1] && (h2 != '0);
    st0_next.zero  = (h2 == '0);
  end

  // Entry stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= st0_next;
    end
  end

  // One quotient bit per stage for both coordinates.
  for (genvar t = 0; t < DIV_STEPS; t++) begin : g_step
    logic [H_W:0] res_u;
    logic [H_W:0] res_v;
    div_t         step_next;

    assign res_u = div_bit(st[t].r_u, st[t].lo_u[LO_W-1], st[t].b);
    assign res_v = div_bit(st[t].r_v, st[t].lo_v[LO_W-1], st[t].b);

    // Carry the stage forward with the new remainders and quotient bits.
    always_comb begin
      step_next      = st[t];
      step_next.r_u  = res_u[H_W-1:0];
      step_next.r_v  = res_v[H_W-1:0];
      step_next.lo_u = {st[t].lo_u[LO_W-2:0], 1'b0};
      step_next.lo_v = {st[t].lo_v[LO_W-2:0], 1'b0};
      step_next.q_u  = {st[t].q_u[QUO_W-2:0], res_u[H_W]};
      step_next.q_v  = {st[t].q_v[QUO_W-2:0], res_v[H_W]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[t+1] <= 1'b0;
      end else if (en) begin
        vs[t+1] <= vs[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[t+1] <= step_next;
      end
    end
  end

  // Saturation, sign and zero-depth forcing into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_front   <= last.front;
      depth_zero <= last.zero;
      if (last.zero) begin
        pixel_u <= '0;
      end else if (last.neg_u) begin
        pixel_u <= (last.ovf_u || last.q_u > NEG_LIM) ? MIN_W
                                                     : COORD_W'(-last.q_u);
      end else begin
        pixel_u <= (last.ovf_u || last.q_u[QUO_W-1] || last.q_u[QUO_W-2]) ? MAX_W
                                                     : last.q_u[COORD_W-1:0];
      end
      if (last.zero) begin
        pixel_v <= '0;
      end else if (last.neg_v) begin
        pixel_v <= (last.ovf_v || last.q_v > NEG_LIM) ? MIN_W
                                                     : COORD_W'(-last.q_v);
      end else begin
        pixel_v <= (last.ovf_v || last.q_v[QUO_W-1] || last.q_v[QUO_W-2]) ? MAX_W
                                                     : last.q_v[COORD_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

[sv/pinhole_point_projection.sv]
// Pinhole projection of world points to saturated Q16.16 pixels.
// Path: a word accepted at the input passes 5 transform stages, the queue, 1 entry stage,
// 33 divide stages and the output register.
// Throughput: one word per cycle while out_stall does not hold the back, set by the one-bit-per-stage divide pipeline.
// Reset: synchronous; clears the configuration registers and every valid bit, so all
// stages start empty. Datapath registers are not reset.
`default_nettype none
module pinhole_point_projection #(
  parameter int QUEUE_DEPTH = ppp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [ppp_pkg::IDX_W-1:0]          cfg_index,
  input  wire logic [ppp_pkg::REG_W-1:0]          cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] point_x,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] point_y,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] point_z,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [ppp_pkg::COORD_W-1:0]      pixel_u,
  output logic signed [ppp_pkg::COORD_W-1:0]      pixel_v,
  output logic                                    in_front,
  output logic                                    depth_zero
);
  import ppp_pkg::*;

  cfg_t  cfg;
  hvec_t q_data;
  hvec_t q_head;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_K_A: cfg.k_a <= cfg_data;
        REG_K_B: cfg.k_b <= cfg_data;
        REG_K_C: cfg.k_c <= cfg_data;
        REG_R_A: cfg.r_a <= cfg_data;
        REG_R_B: cfg.r_b <= cfg_data;
        REG_R_C: cfg.r_c <= cfg_data;
        REG_CAM: cfg.cam <= cfg_data;
        default: ;
      endcase
    end
  end

  ppp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  ppp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  ppp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_u    (pixel_u),
    .pixel_v    (pixel_v),
    .in_front   (in_front),
    .depth_zero (depth_zero)
  );

endmodule
`default_nettype wire
